[rtl/prw_pkg.sv]
// Shared types and constants for the base-relocation walker.
package prw_pkg;

   // Entry type codes that produce a patch.
   localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
   localparam logic [3:0] TYPE_DIR64   = 4'd10;

   // A block header is two 32-bit words.
   localparam logic [31:0] HEADER_BYTES = 32'd8;

   // Entries in a block: (size / 2) - 4, held in 31 bits.
   localparam logic [30:0] HEADER_HALFWORDS = 31'd4;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_DELTA    = 2'd0,
      CSR_DIR_SIZE = 2'd1
   } csr_index_type;

   // Walk phases: four header halfwords, then entries.
   typedef enum logic [4:0] {
      PH_RVA_LO  = 5'b00001,
      PH_RVA_HI  = 5'b00010,
      PH_SIZE_LO = 5'b00100,
      PH_SIZE_HI = 5'b01000,
      PH_ENTRY   = 5'b10000
   } phase_type;

   // One configuration write.
   typedef struct packed {
      logic          write;
      csr_index_type index;
      logic [63:0]   data;
   } cfg_write_type;

   // One patch command from the walker.
   typedef struct packed {
      logic        valid;
      logic [31:0] patch_rva;
      logic        patch_wide;
      logic [63:0] add_value;
   } patch_type;

endpackage

[rtl/prw_walker.sv]
// Directory walk state machine, configuration registers and entry decode.
module prw_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [15:0]           halfword,
   input  logic                  first,
   input  prw_pkg::cfg_write_type cfg,
   output prw_pkg::patch_type    patch
);
   import prw_pkg::*;

   logic [63:0] delta_ff, delta_in;
   logic [31:0] dir_size_ff, dir_size_in;
   phase_type   phase_ff, phase_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] block_rva_ff, block_rva_in;
   logic [15:0] size_lo_ff, size_lo_in;
   logic [30:0] entries_ff, entries_in;
   logic [31:0] bytes_ff, bytes_in;

   logic        eff_stopped;
   phase_type   eff_phase;
   logic [31:0] eff_bytes;
   logic [31:0] full_size;
   logic [30:0] new_entries;
   logic [32:0] byte_sum;
   logic [30:0] entries_dec;
   logic [3:0]  kind;

   // Configuration writes.
   always_comb begin
      delta_in    = delta_ff;
      dir_size_in = dir_size_ff;
      if (cfg.write) begin
         unique case (cfg.index)
            CSR_DELTA:    delta_in    = cfg.data;
            CSR_DIR_SIZE: dir_size_in = cfg.data[31:0];
            default: begin
            end
         endcase
      end
   end

   // A word marked first restarts the walk before it is decoded.
   assign eff_stopped = first ? 1'b0 : stopped_ff;
   assign eff_phase   = first ? PH_RVA_LO : phase_ff;
   assign eff_bytes   = first ? 32'd0 : bytes_ff;

   // Header arithmetic; the low bit of the block size is dropped.
   assign full_size   = {halfword, size_lo_ff};
   assign new_entries = full_size[31:1] - HEADER_HALFWORDS;
   assign byte_sum    = {1'b0, eff_bytes} + {1'b0, full_size[31:1], 1'b0};
   assign entries_dec = entries_ff - 31'd1;
   assign kind        = halfword[15:12];

   // Walk state update and patch decode.
   always_comb begin
      phase_in     = phase_ff;
      stopped_in   = stopped_ff;
      block_rva_in = block_rva_ff;
      size_lo_in   = size_lo_ff;
      entries_in   = entries_ff;
      bytes_in     = bytes_ff;
      patch        = '0;
      patch.patch_rva  = block_rva_ff + {20'd0, halfword[11:0]};
      patch.patch_wide = (kind == TYPE_DIR64);
      patch.add_value  = (kind == TYPE_DIR64) ? delta_ff : {32'd0, delta_ff[31:0]};
      if (accept && !eff_stopped) begin
         stopped_in = 1'b0;
         bytes_in   = eff_bytes;
         unique case (eff_phase)
            PH_RVA_LO: begin
               if (eff_bytes >= dir_size_ff) begin
                  stopped_in = 1'b1;
                  phase_in   = PH_RVA_LO;
               end else begin
                  block_rva_in = {16'd0, halfword};
                  phase_in     = PH_RVA_HI;
               end
            end
            PH_RVA_HI: begin
               block_rva_in = {halfword, block_rva_ff[15:0]};
               phase_in     = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
               size_lo_in = halfword;
               phase_in   = PH_SIZE_HI;
            end
            PH_SIZE_HI: begin
               if (full_size < HEADER_BYTES) begin
                  stopped_in = 1'b1;
                  phase_in   = PH_RVA_LO;
               end else begin
                  entries_in = new_entries;
                  bytes_in   = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
                  phase_in   = (new_entries == 31'd0) ? PH_RVA_LO : PH_ENTRY;
               end
            end
            PH_ENTRY: begin
               entries_in = entries_dec;
               if (entries_dec == 31'd0) begin
                  phase_in = PH_RVA_LO;
               end
               patch.valid = (delta_ff != 64'd0) &&
                             ((kind == TYPE_HIGHLOW) || (kind == TYPE_DIR64));
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff     <= '0;
         dir_size_ff  <= '0;
         phase_ff     <= PH_RVA_LO;
         stopped_ff   <= 1'b1;
         block_rva_ff <= '0;
         size_lo_ff   <= '0;
         entries_ff   <= '0;
         bytes_ff     <= '0;
      end else begin
         delta_ff     <= delta_in;
         dir_size_ff  <= dir_size_in;
         phase_ff     <= phase_in;
         stopped_ff   <= stopped_in;
         block_rva_ff <= block_rva_in;
         size_lo_ff   <= size_lo_in;
         entries_ff   <= entries_in;
         bytes_ff     <= bytes_in;
      end
   end

endmodule

[rtl/prw_out_buf.sv]
// Result register with a skid entry between the walker and the result channel.
module prw_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  prw_pkg::patch_type push,
   input  logic               rsp_stall,
   output logic               full,
   output logic               rsp_valid,
   output logic [31:0]        rsp_patch_rva,
   output logic               rsp_patch_wide,
   output logic [63:0]        rsp_add_value
);
   import prw_pkg::*;

   logic      out_valid_ff, out_valid_in;
   patch_type out_ff, out_in;
   logic      skid_valid_ff, skid_valid_in;
   patch_type skid_ff, skid_in;
   logic      pop;

   assign pop = out_valid_ff && !rsp_stall;

   // Move words between the skid entry and the result register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push.valid) begin
            out_in = push;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (out_valid_ff) begin
            skid_in       = push;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = push;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full           = skid_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_patch_rva  = out_ff.patch_rva;
   assign rsp_patch_wide = out_ff.patch_wide;
   assign rsp_add_value  = out_ff.add_value;

endmodule

[rtl/pe_base_relocation_walker.sv]
// Top level of the PE base-relocation directory walker.
// The walker takes the relocation directory as a stream of little-endian
// halfwords, one word per cycle while req_stall is low, and emits one patch
// command (address, width, value to add) for every HIGHLOW or DIR64 entry if
// delta is nonzero. Each word is decoded in the cycle it is accepted and its
// command registered in the result register or its one-word skid entry; the
// rate is set by these two slots, which sustain one word per cycle as long
// as the result channel does not stall. req_stall rises only when both result
// slots are full. Set delta and dir_size through the configuration port while
// the walker is idle; a halfword with req_first set restarts the walk.
module pe_base_relocation_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_reloc_halfword,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_patch_rva,
   output logic        rsp_patch_wide,
   output logic [63:0] rsp_add_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import prw_pkg::*;

   cfg_write_type cfg;
   patch_type     patch;
   logic          full;
   logic          accept;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg.write = csr_valid && csr_ready;
   assign cfg.index = csr_index_type'(csr_index);
   assign cfg.data  = csr_wdata;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   prw_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .halfword (req_reloc_halfword),
      .first    (req_first),
      .cfg      (cfg),
      .patch    (patch)
   );

   prw_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .push           (patch),
      .rsp_stall      (rsp_stall),
      .full           (full),
      .rsp_valid      (rsp_valid),
      .rsp_patch_rva  (rsp_patch_rva),
      .rsp_patch_wide (rsp_patch_wide),
      .rsp_add_value  (rsp_add_value)
   );

endmodule

[tb/tb_pe_base_relocation_walker.sv]
// Self-checking testbench for the PE base-relocation directory walker.
`timescale 1ns / 1ps

// Tracks the walk of the relocation directory and holds the patch words it should emit.
class patch_ledger;
   typedef struct {
      logic [31:0] rva;
      logic        wide;
      logic [63:0] add;
   } patch_cmd_type;

   patch_cmd_type pending_patches[$];
   int unsigned mismatches = 0;

   // Register copies.
   logic [63:0] delta = '0;
   logic [31:0] dir_size = '0;

   // Walk state.
   prw_pkg::phase_type phase = prw_pkg::PH_RVA_LO;
   logic [31:0] block_rva = '0;
   logic [31:0] block_size = '0;
   logic [30:0] entries_left = '0;
   logic [31:0] bytes_consumed = '0;
   logic        stopped = 1'b1;

   function void set_register(prw_pkg::csr_index_type idx, logic [63:0] value);
      if (idx == prw_pkg::CSR_DELTA) begin
         delta = value;
      end else if (idx == prw_pkg::CSR_DIR_SIZE) begin
         dir_size = value[31:0];
      end
   endfunction

   // Advance the walk by one accepted halfword and queue the patch it causes.
   function void take_halfword(logic [15:0] hw, logic first);
      logic [31:0]   even;
      logic [32:0]   sum;
      logic [3:0]    kind;
      patch_cmd_type cmd;
      if (first) begin
         phase = prw_pkg::PH_RVA_LO;
         block_rva = '0;
         block_size = '0;
         entries_left = '0;
         bytes_consumed = '0;
         stopped = 1'b0;
      end
      if (stopped) return;
      case (phase)
         prw_pkg::PH_RVA_LO: begin
            // A header due with the directory used up ends the walk.
            if (bytes_consumed >= dir_size) begin
               stopped = 1'b1;
            end else begin
               block_rva = {16'h0000, hw};
               phase = prw_pkg::PH_RVA_HI;
            end
         end
         prw_pkg::PH_RVA_HI: begin
            block_rva[31:16] = hw;
            phase = prw_pkg::PH_SIZE_LO;
         end
         prw_pkg::PH_SIZE_LO: begin
            block_size = {16'h0000, hw};
            phase = prw_pkg::PH_SIZE_HI;
         end
         prw_pkg::PH_SIZE_HI: begin
            block_size[31:16] = hw;
            // A block shorter than its own header ends the walk.
            if (block_size < prw_pkg::HEADER_BYTES) begin
               stopped = 1'b1;
               phase = prw_pkg::PH_RVA_LO;
            end else begin
               even = {block_size[31:1], 1'b0};
               entries_left = block_size[31:1] - prw_pkg::HEADER_HALFWORDS;
               sum = {1'b0, bytes_consumed} + {1'b0, even};
               bytes_consumed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               phase = (entries_left == '0) ? prw_pkg::PH_RVA_LO : prw_pkg::PH_ENTRY;
            end
         end
         prw_pkg::PH_ENTRY: begin
            kind = hw[15:12];
            entries_left = entries_left - 31'd1;
            if (entries_left == '0) phase = prw_pkg::PH_RVA_LO;
            if (delta != '0 &&
                (kind == prw_pkg::TYPE_HIGHLOW || kind == prw_pkg::TYPE_DIR64)) begin
               cmd.rva = block_rva + {20'h00000, hw[11:0]};
               cmd.wide = (kind == prw_pkg::TYPE_DIR64);
               cmd.add = cmd.wide ? delta : {32'h0000_0000, delta[31:0]};
               pending_patches.push_back(cmd);
            end
         end
         default: ;
      endcase
   endfunction

   // Compare one accepted patch word with the oldest one waiting.
   function void match_patch(logic [31:0] rva, logic wide, logic [63:0] add);
      patch_cmd_type want;
      if (pending_patches.size() == 0) begin
         $error("unexpected patch word: patch_rva %h patch_wide %b add_value %h", rva, wide, add);
         mismatches++;
         return;
      end
      want = pending_patches.pop_front();
      if (rva !== want.rva) begin
         $error("patch_rva: expected %h, got %h", want.rva, rva);
         mismatches++;
      end
      if (wide !== want.wide) begin
         $error("patch_wide: expected %b, got %b", want.wide, wide);
         mismatches++;
      end
      if (add !== want.add) begin
         $error("add_value: expected %h, got %h", want.add, add);
         mismatches++;
      end
   endfunction
endclass

module tb_pe_base_relocation_walker;
   import prw_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES = 12;
   localparam int HALFWORDS_PER_PHASE = 75;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_reloc_halfword;
   logic        req_first;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_patch_rva;
   logic        rsp_patch_wide;
   logic [63:0] rsp_add_value;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   patch_ledger ledger = new;

   int          halfwords_sent = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          rsp_hold = 0;
   logic [31:0] dir_bytes = '0;

   pe_base_relocation_walker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reloc_halfword (req_reloc_halfword),
      .req_first          (req_first),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_patch_rva      (rsp_patch_rva),
      .rsp_patch_wide     (rsp_patch_wide),
      .rsp_add_value      (rsp_add_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none when pct is zero.
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   // Result-side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_hold = pick_gap(rsp_stall_pct);
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // Watch both channels; results are checked before the new word is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            ledger.match_patch(rsp_patch_rva, rsp_patch_wide, rsp_add_value);
         end
         if (req_valid && !req_stall) begin
            ledger.take_halfword(req_reloc_halfword, req_first);
         end
      end
   end

   // Hard stop in case the walker hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_halfword(input logic [15:0] hw, input logic first);
      int gap;
      req_valid <= 1'b1;
      req_reloc_halfword <= hw;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      halfwords_sent++;
      gap = pick_gap(req_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let the walker drain: every expected patch out, then a few spare cycles.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (ledger.pending_patches.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write delta, then dir_size, holding valid high across both words.
   task automatic load_config(input logic [63:0] delta, input logic [31:0] size);
      csr_valid <= 1'b1;
      csr_index <= CSR_DELTA;
      csr_wdata <= delta;
      do @(posedge clock); while (!csr_ready);
      ledger.set_register(CSR_DELTA, delta);
      csr_index <= CSR_DIR_SIZE;
      csr_wdata <= {32'h0000_0000, size};
      do @(posedge clock); while (!csr_ready);
      ledger.set_register(CSR_DIR_SIZE, {32'h0000_0000, size});
      dir_bytes = size;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [3:0] pick_type();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return TYPE_HIGHLOW;
      if (r < 65) return TYPE_DIR64;
      return 4'($urandom_range(0, 15));
   endfunction

   // One directory: a restart, then blocks until the size runs out, a short block
   // ends it, or it is cut off and the next directory restarts the walk.
   task automatic send_directory();
      logic [31:0] walked;
      logic [31:0] rva;
      logic [31:0] size;
      logic [32:0] sum;
      logic        lead;
      int          n_blocks;
      int          n_entries;
      int          kind;
      walked = '0;
      lead = 1'b1;
      n_blocks = $urandom_range(1, 6);
      for (int b = 0; b < n_blocks; b++) begin
         if (walked >= dir_bytes) begin
            // Directory used up: this and the trailing words land on a stopped walk.
            send_halfword(16'($urandom), lead);
            repeat ($urandom_range(0, 3)) send_halfword(16'($urandom), 1'b0);
            return;
         end
         kind = $urandom_range(0, 99);
         n_entries = $urandom_range(0, 10);
         size = 32'd8 + 32'(2 * n_entries);
         if (kind < 6) size = 32'($urandom_range(0, 7));
         else if (kind < 14) size = size | 32'd1;
         else if (kind < 17) size = $urandom | 32'h0001_0000;
         rva = $urandom;
         if ($urandom_range(0, 4) == 0) rva[31:12] = '1;
         send_halfword(rva[15:0], lead);
         lead = 1'b0;
         send_halfword(rva[31:16], 1'b0);
         send_halfword(size[15:0], 1'b0);
         send_halfword(size[31:16], 1'b0);
         if (size < 32'd8) begin
            repeat ($urandom_range(0, 3)) send_halfword(16'($urandom), 1'b0);
            return;
         end
         sum = {1'b0, walked} + {1'b0, size[31:1], 1'b0};
         walked = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         // Oversized blocks only get a few entries before the next restart.
         if (size > 32'hFFFF) n_entries = $urandom_range(1, 12);
         else n_entries = int'(size[31:1]) - 4;
         for (int e = 0; e < n_entries; e++) begin
            if ($urandom_range(0, 99) < 3) return;
            send_halfword({pick_type(), 12'($urandom)}, 1'b0);
         end
         if (size > 32'hFFFF) return;
      end
   endtask

   initial begin
      logic [63:0] delta;
      logic [31:0] size;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_reloc_halfword <= '0;
      req_first <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_DELTA;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the walk is stopped and dir_size is zero.
      send_halfword(16'h1234, 1'b0);
      send_halfword(16'hFFFF, 1'b1);
      send_halfword(16'h0000, 1'b0);
      wait_idle();

      // Full-width delta, endless directory.
      load_config(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      // Block at the top of the address space, odd size: RVA wraps on the add.
      send_halfword(16'hFFFF, 1'b1);
      send_halfword(16'hFFFF, 1'b0);
      send_halfword(16'h000D, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword({TYPE_HIGHLOW, 12'hFFF}, 1'b0);
      send_halfword({TYPE_DIR64, 12'hFFF}, 1'b0);
      // Header-only block, then a block with a skipped type.
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h0009, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h1000, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h000C, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h0123, 1'b0);
      send_halfword({TYPE_HIGHLOW, 12'h000}, 1'b0);
      // Block shorter than a header stops the walk; the next word is dropped.
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword(16'h0004, 1'b0);
      send_halfword(16'h0000, 1'b0);
      send_halfword({TYPE_DIR64, 12'hABC}, 1'b0);

      // Random directories under a range of register settings.
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 4))
            0: delta = 64'hFFFF_FFFF_FFFF_FFFF;
            1: delta = 64'h0000_0000_FFFF_FFFF;
            2: delta = 64'hFFFF_FFFF_0000_0000;
            default: delta = {$urandom, $urandom};
         endcase
         if (p == 2) delta = '0;
         if (p == 4) size = '0;
         else if (p == 5) size = 32'hFFFF_FFFF;
         else if ($urandom_range(0, 5) == 0) size = $urandom;
         else size = 32'($urandom_range(8, 160));
         wait_idle();
         load_config(delta, size);
         if (p % 4 == 1) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct = $urandom_range(10, 50);
            rsp_stall_pct = $urandom_range(10, 50);
         end
         size = 32'(halfwords_sent + HALFWORDS_PER_PHASE);
         while (halfwords_sent < int'(size)) send_directory();
      end

      req_valid <= 1'b0;
      while (ledger.pending_patches.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_patches.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[pe_base_relocation_walker.f]
rtl/prw_pkg.sv
rtl/prw_walker.sv
rtl/prw_out_buf.sv
rtl/pe_base_relocation_walker.sv
tb/tb_pe_base_relocation_walker.sv
